// ===== hw/rtl/dlrq_pkg.sv =====
package dlrq_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH    = 3'd0,
		CMD_UNSHIFT = 3'd1,
		CMD_SHIFT   = 3'd2,
		CMD_DELETE  = 3'd3,
		CMD_FIND    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_EMPTY      = 3'd1,
		ST_NOT_FOUND  = 3'd2,
		ST_NOT_QUEUED = 3'd3,
		ST_ALREADY    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_UNL,
		S_FIND,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [5:0]  entry_index;
		logic [31:0] key_value;
	} req_t;

	typedef struct packed {
		logic [5:0] result_entry;
		logic [2:0] status;
	} rsp_t;

endpackage

// ===== hw/rtl/doubly_linked_run_queue_core.sv =====
// Insert uses S_INS, remove head and delete use S_UNL; S_RESP registers the result.
// A rejected request goes straight to S_RESP; find walks until a key match or the tail.
// One request is in work at a time; the link and key memory read port sets the walk rate.
// The response register frees the datapath as soon as the result is loaded.
// Reset empties the queue and clears all queued bits; link and key memories keep no reset.
module doubly_linked_run_queue_core import dlrq_pkg::*; #(
	parameter int POOL_ENTRIES = 64,
	parameter int KEY_BITS     = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IW = $clog2(POOL_ENTRIES);
	localparam int LW = $clog2(POOL_ENTRIES + 1);
	localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

	state_t state_q, state_d;

	logic [2:0]          cmd_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       cur_q;
	logic [KEY_BITS-1:0] key_q;
	logic [LW-1:0]       head_q, tail_q;
	logic [POOL_ENTRIES-1:0] queued_q;
	logic [5:0]          res_q;
	status_t             st_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [IW-1:0]       req_idx;
	logic                in_range;
	logic                req_queued;
	logic                head_nil, tail_nil;
	state_t              dec_state;
	status_t             dec_status;

	logic [IW-1:0]       raddr;
	logic                next_we, prev_we, key_we;
	logic [IW-1:0]       next_waddr, prev_waddr;
	logic [LW-1:0]       next_wdata, prev_wdata;
	logic [LW-1:0]       next_rd, prev_rd;
	logic [KEY_BITS-1:0] key_rd;

	logic [LW-1:0]       e_link;
	logic [LW-1:0]       p_eff, n_eff;
	logic                key_match;
	logic                rsp_free;

	assign req_ready  = (state_q == S_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign rsp_free   = !rsp_valid_q || rsp_ready;

	assign req_idx    = IW'(req.entry_index);
	assign in_range   = (32'(req.entry_index) < 32'(POOL_ENTRIES));
	assign req_queued = in_range && queued_q[req_idx];
	assign head_nil   = (head_q == NIL);
	assign tail_nil   = (tail_q == NIL);

	assign e_link     = LW'(idx_q);
	assign p_eff      = (head_q == e_link) ? NIL : prev_rd;
	assign n_eff      = (tail_q == e_link) ? NIL : next_rd;
	assign key_match  = (key_rd == key_q);

	always_comb begin
		dec_state  = S_RESP;
		dec_status = ST_OK;
		unique case (req.command)
			CMD_PUSH, CMD_UNSHIFT: begin
				if (!in_range) begin
					dec_status = ST_NOT_QUEUED;
				end else if (req_queued) begin
					dec_status = ST_ALREADY;
				end else begin
					dec_state = S_INS;
				end
			end
			CMD_DELETE: begin
				if (!req_queued) begin
					dec_status = ST_NOT_QUEUED;
				end else begin
					dec_state = S_UNL;
				end
			end
			CMD_SHIFT: begin
				if (head_nil) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_state = S_UNL;
				end
			end
			CMD_FIND: begin
				dec_status = ST_NOT_FOUND;
				if (!head_nil) begin
					dec_state = S_FIND;
				end
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = dec_state;
				end
			end
			S_INS:  state_d = S_RESP;
			S_UNL:  state_d = S_RESP;
			S_FIND: begin
				if (key_match || (LW'(cur_q) == tail_q)) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		raddr      = idx_q;
		next_we    = 1'b0;
		next_waddr = idx_q;
		next_wdata = NIL;
		prev_we    = 1'b0;
		prev_waddr = idx_q;
		prev_wdata = NIL;
		key_we     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req.command == CMD_SHIFT || req.command == CMD_FIND) begin
					raddr = head_q[IW-1:0];
				end else begin
					raddr = req_idx;
				end
			end
			S_INS: begin
				key_we = 1'b1;
				if (cmd_q == CMD_PUSH) begin
					prev_we    = 1'b1;
					prev_waddr = idx_q;
					prev_wdata = tail_q;
					next_we    = !tail_nil;
					next_waddr = tail_q[IW-1:0];
					next_wdata = e_link;
				end else begin
					next_we    = 1'b1;
					next_waddr = idx_q;
					next_wdata = head_q;
					prev_we    = !head_nil;
					prev_waddr = head_q[IW-1:0];
					prev_wdata = e_link;
				end
			end
			S_UNL: begin
				next_we    = (p_eff != NIL);
				next_waddr = p_eff[IW-1:0];
				next_wdata = n_eff;
				prev_we    = (n_eff != NIL);
				prev_waddr = n_eff[IW-1:0];
				prev_wdata = p_eff;
			end
			S_FIND: begin
				raddr = next_rd[IW-1:0];
			end
			S_RESP: begin
				raddr = idx_q;
			end
			default: begin
				raddr = idx_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= NIL;
			tail_q      <= NIL;
			queued_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INS) begin
				queued_q[idx_q] <= 1'b1;
				if (cmd_q == CMD_PUSH) begin
					if (tail_nil) begin
						head_q <= e_link;
					end
					tail_q <= e_link;
				end else begin
					if (head_nil) begin
						tail_q <= e_link;
					end
					head_q <= e_link;
				end
			end
			if (state_q == S_UNL) begin
				queued_q[idx_q] <= 1'b0;
				if (head_q == e_link) begin
					head_q <= n_eff;
				end
				if (tail_q == e_link) begin
					tail_q <= p_eff;
				end
			end
			if (state_q == S_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd_q <= req.command;
					key_q <= KEY_BITS'(req.key_value);
					cur_q <= head_q[IW-1:0];
					st_q  <= dec_status;
					if (req.command == CMD_SHIFT) begin
						idx_q <= head_q[IW-1:0];
						res_q <= head_nil ? 6'd0 : 6'(head_q);
					end else begin
						idx_q <= req_idx;
						res_q <= 6'd0;
					end
				end
			end
			S_FIND: begin
				if (key_match) begin
					res_q <= 6'(cur_q);
					st_q  <= ST_OK;
				end else begin
					cur_q <= next_rd[IW-1:0];
				end
			end
			S_RESP: begin
				if (rsp_free) begin
					rsp_q.result_entry <= res_q;
					rsp_q.status       <= st_q;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	dlrq_ram #(
		.DEPTH(POOL_ENTRIES),
		.WIDTH(LW)
	) u_next_ram (
		.clk  (clk),
		.we   (next_we),
		.waddr(next_waddr),
		.wdata(next_wdata),
		.raddr(raddr),
		.rdata(next_rd)
	);

	dlrq_ram #(
		.DEPTH(POOL_ENTRIES),
		.WIDTH(LW)
	) u_prev_ram (
		.clk  (clk),
		.we   (prev_we),
		.waddr(prev_waddr),
		.wdata(prev_wdata),
		.raddr(raddr),
		.rdata(prev_rd)
	);

	dlrq_ram #(
		.DEPTH(POOL_ENTRIES),
		.WIDTH(KEY_BITS)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(idx_q),
		.wdata(key_q),
		.raddr(raddr),
		.rdata(key_rd)
	);

endmodule

// ===== hw/rtl/dlrq_ram.sv =====
module dlrq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 7
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
